// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the LZ77 token decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/lzd_pkg.sv -----
// Types and codes shared by the LZ77 token decoder controller and datapath.
package lzd_pkg;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_OFFSET = 2'd1,
    STATUS_PAST_END   = 2'd2,
    STATUS_HALTED     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_READ,
    S_BYTE,
    S_EMIT,
    S_ERR
  } state_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_DIRECT,
    OUT_PACK,
    OUT_ERR
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     start;
    logic     rd;
    logic     take;
    logic     finish;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    status_t err;
    logic    last_byte;
    logic    word_done;
    logic    pack_last;
    logic    out_free;
  } sts_t;

endpackage

// ----- rtl/lzd_ctrl.sv -----
// Controller state machine sequencing the check, copy and packing of each token.
module lzd_ctrl
  import lzd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  input  sts_t    sts,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.out_sel = OUT_NONE;
    in_stall    = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err != STATUS_OK) begin
          state_next = S_ERR;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_BYTE;
      end
      S_BYTE: begin
        cmd.take = 1'b1;
        if (!sts.word_done) begin
          cmd.rd = 1'b1;
        end else if (sts.out_free) begin
          cmd.out_sel = OUT_DIRECT;
          if (sts.last_byte) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.rd = 1'b1;
          end
        end else begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_sel = OUT_PACK;
          if (sts.pack_last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.out_sel = OUT_ERR;
          cmd.finish  = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/lzd_datapath.sv -----
// Datapath: token checks, history ring, byte packing and the result register.
module lzd_datapath
  import lzd_pkg::*;
#(
  parameter int WINDOW  = 16384,
  parameter int MAX_RUN = 128,
  parameter int LANES   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic                         cfg_we,
  input  logic [23:0]                  cfg_total_size,
  input  logic [14:0]                  match_offset,
  input  logic [7:0]                   copy_length,
  input  logic [7:0]                   literal_byte,
  input  logic                         last_token,
  output logic [LANES*8-1:0]           out_bytes,
  output logic [$clog2(LANES+1)-1:0]   byte_count,
  output logic [1:0]                   status,
  output logic                         run_end,
  output logic                         out_valid,
  input  logic                         out_stall
);

  localparam int AW = $clog2(WINDOW);
  localparam int RW = $clog2(MAX_RUN + 2);
  localparam int LW = $clog2(LANES);
  localparam int CW = $clog2(LANES + 1);
  localparam int DW = LANES * 8;
  localparam logic [AW-1:0] WLAST = AW'(WINDOW - 1);

  logic [7:0]    hist [WINDOW];

  logic [23:0]   total_size;
  logic [23:0]   produced;
  logic          halted;
  logic [AW-1:0] wptr;
  logic [AW-1:0] src;
  logic [14:0]   tok_off;
  logic [7:0]    tok_len;
  logic [7:0]    tok_lit;
  logic          tok_last;
  logic [RW-1:0] n_bytes;
  logic [RW-1:0] idx;
  logic [7:0]    rd_data;
  logic [7:0]    prev;
  logic [DW-1:0] pack;
  logic [LW-1:0] lc;
  logic [CW-1:0] pack_cnt;
  logic          pack_last;

  logic [24:0]   end_pos;
  logic          bad_off;
  status_t       err;
  logic [24:0]   wptr_w;
  logic [24:0]   off_w;
  logic [24:0]   src_start;
  logic [AW-1:0] src_inc;
  logic [AW-1:0] wptr_inc;
  logic [AW-1:0] raddr;
  logic [7:0]    byte_val;
  logic [DW-1:0] combined;
  logic          last_byte;
  logic          word_done;
  logic          out_free;
  logic [RW-1:0] n_calc;

  always_comb begin
    end_pos = 25'(produced) + 25'(tok_len);
    bad_off = (tok_len > 8'(MAX_RUN)) || (tok_off == '0) ||
              (25'(tok_off) > 25'(produced)) || (25'(tok_off) > 25'(WINDOW));
    if (halted) begin
      err = STATUS_HALTED;
    end else if (tok_len == '0) begin
      err = (produced >= total_size) ? STATUS_PAST_END : STATUS_OK;
    end else if (bad_off) begin
      err = STATUS_BAD_OFFSET;
    end else if (end_pos > 25'(total_size)) begin
      err = STATUS_PAST_END;
    end else begin
      err = STATUS_OK;
    end
  end

  always_comb begin
    wptr_w    = 25'(wptr);
    off_w     = 25'(tok_off);
    src_start = (wptr_w >= off_w) ? (wptr_w - off_w) : (wptr_w + 25'(WINDOW) - off_w);
    src_inc   = (src == WLAST) ? '0 : src + AW'(1);
    wptr_inc  = (wptr == WLAST) ? '0 : wptr + AW'(1);
    raddr     = cmd.take ? src_inc : src;
    if (tok_len == '0) begin
      n_calc = RW'(1);
    end else begin
      n_calc = RW'(tok_len) + RW'(end_pos < 25'(total_size));
    end
  end

  always_comb begin
    if (8'(idx) == tok_len) begin
      byte_val = tok_lit;
    end else if ((tok_off == 15'd1) && (idx != '0)) begin
      byte_val = prev;
    end else begin
      byte_val = rd_data;
    end
    combined              = pack;
    combined[{lc, 3'b000} +: 8] = byte_val;
    last_byte             = (idx == n_bytes - RW'(1));
    word_done             = (lc == LW'(LANES - 1)) || last_byte;
    out_free              = !out_valid || !out_stall;
  end

  assign sts = '{err: err, last_byte: last_byte, word_done: word_done,
                 pack_last: pack_last, out_free: out_free};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hist[wptr] <= byte_val;
    end
    if (cmd.rd) begin
      rd_data <= hist[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tok_off  <= match_offset;
      tok_len  <= copy_length;
      tok_lit  <= literal_byte;
      tok_last <= last_token;
    end
    if (cmd.start) begin
      src     <= src_start[AW-1:0];
      n_bytes <= n_calc;
      idx     <= '0;
      lc      <= '0;
      pack    <= '0;
    end
    if (cmd.take) begin
      src  <= src_inc;
      idx  <= idx + RW'(1);
      prev <= byte_val;
      if (word_done) begin
        lc <= '0;
        if (cmd.out_sel == OUT_DIRECT) begin
          pack <= '0;
        end else begin
          pack      <= combined;
          pack_cnt  <= CW'(lc) + CW'(1);
          pack_last <= last_byte;
        end
      end else begin
        pack <= combined;
        lc   <= lc + LW'(1);
      end
    end
    if (cmd.out_sel == OUT_PACK) begin
      pack <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_size <= '0;
      produced   <= '0;
      halted     <= 1'b0;
      wptr       <= '0;
    end else begin
      if (cfg_we) begin
        total_size <= cfg_total_size;
      end
      if (cmd.finish && tok_last) begin
        wptr <= '0;
      end else if (cmd.take) begin
        wptr <= wptr_inc;
      end
      if (cmd.finish) begin
        if (tok_last) begin
          produced <= '0;
          halted   <= 1'b0;
        end else if (err != STATUS_OK) begin
          halted <= 1'b1;
        end else begin
          produced <= 24'(25'(produced) + 25'(n_bytes));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_sel != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.out_sel)
      OUT_DIRECT: begin
        out_bytes  <= combined;
        byte_count <= CW'(lc) + CW'(1);
        status     <= STATUS_OK;
        run_end    <= last_byte;
      end
      OUT_PACK: begin
        out_bytes  <= pack;
        byte_count <= pack_cnt;
        status     <= STATUS_OK;
        run_end    <= pack_last;
      end
      OUT_ERR: begin
        out_bytes  <= '0;
        byte_count <= '0;
        status     <= err;
        run_end    <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/lz77_token_decoder_top.sv -----
// Top level of the LZ77 token decoder: controller, datapath and checks.
//
// Tokens enter on the input channel (in_valid, in_stall); decoded bytes leave
// on the output channel (out_valid, out_stall), packed LANES to a beat, first
// byte in the low lane, with run_end on the last beat of each token. A token
// is taken only when the block is idle. It is checked in the cycle after it
// is taken, then its bytes are copied one per cycle while the receiver does
// not stall, through the single read and write port of the history memory.
// A token that decodes n bytes (a copy of L bytes and its literal gives
// n = L + 1, at most 129, or L when the copy ends at the total size) holds
// the input until its last beat or its error beat enters the result register.
// The result register lets the next beat be prepared while one waits; when
// the receiver stalls, the copy pauses with that beat held. The total size
// register is to be written on the cfg channel while idle; the block does not
// enforce this. Reset clears the byte count, the halt flag, the total size and
// the output valid; history contents are left as they are and need no clearing.
`include "assert_macros.svh"
module lz77_token_decoder_top
  import lzd_pkg::*;
#(
  parameter int WINDOW  = 16384,
  parameter int MAX_RUN = 128,
  parameter int LANES   = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [23:0]                total_size,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [14:0]                match_offset,
  input  logic [7:0]                 copy_length,
  input  logic [7:0]                 literal_byte,
  input  logic                       last_token,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LANES*8-1:0]         out_bytes,
  output logic [$clog2(LANES+1)-1:0] byte_count,
  output logic [1:0]                 status,
  output logic                       run_end
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  lzd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lzd_datapath #(
    .WINDOW  (WINDOW),
    .MAX_RUN (MAX_RUN),
    .LANES   (LANES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_total_size (total_size),
    .match_offset   (match_offset),
    .copy_length    (copy_length),
    .literal_byte   (literal_byte),
    .last_token     (last_token),
    .out_bytes      (out_bytes),
    .byte_count     (byte_count),
    .status         (status),
    .run_end        (run_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall)
  );

  `ASSERT_IMP(a_err_beat_empty, clk, rst, out_valid && (status != STATUS_OK), (byte_count == '0) && (out_bytes == '0) && run_end)
  `ASSERT_IMP(a_ok_beat_has_bytes, clk, rst, out_valid && (status == STATUS_OK), byte_count != '0)
  `ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

endmodule
